@@ rtl/kvlt_pkg.sv @@
// Package for the key/value line tokenizer.
// Holds character classes, scanner phases, the result record and the classifier.
// No dependencies.
`default_nettype none

package kvlt_pkg;

  // Default sizes of the block.
  localparam int LINE_LIMIT_DEF  = 256;
  localparam int KEY_LIMIT_DEF   = 64;
  localparam int VALUE_LIMIT_DEF = 128;
  localparam int TABLE_ROWS_DEF  = 64;

  // djb2 seed and field widths.
  localparam logic [63:0] HASH_SEED = 64'd5381;
  localparam int POS_OUT_W = 8;
  localparam int ROW_OUT_W = 6;
  localparam int OVF_W     = 6;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UP_LO  = 8'h41;
  localparam logic [7:0] CH_UP_HI  = 8'h5A;
  localparam logic [7:0] CH_LOW_LO = 8'h61;
  localparam logic [7:0] CH_LOW_HI = 8'h7A;
  localparam logic [7:0] CH_PRT_LO = 8'h21;
  localparam logic [7:0] CH_PRT_HI = 8'h7E;

  typedef enum logic [2:0] {
    CL_INVALID = 3'd0,
    CL_SPACE   = 3'd1,
    CL_DIGIT   = 3'd2,
    CL_UPPER   = 3'd3,
    CL_LOWER   = 3'd4,
    CL_EQUAL   = 3'd5,
    CL_HASH    = 3'd6,
    CL_PUNCT   = 3'd7
  } kvlt_cls_t;

  typedef enum logic [2:0] {
    PH_KEY_SEEK = 3'd0,
    PH_KEY_READ = 3'd1,
    PH_EQ_WAIT  = 3'd2,
    PH_VAL_SEEK = 3'd3,
    PH_VAL_READ = 3'd4
  } kvlt_phase_t;

  // One result beat.
  typedef struct packed {
    logic                 line_ok;
    logic [POS_OUT_W-1:0] key_start;
    logic [POS_OUT_W-1:0] key_end;
    logic [POS_OUT_W-1:0] value_start;
    logic [POS_OUT_W-1:0] value_end;
    logic [63:0]          key_hash;
    logic [ROW_OUT_W-1:0] row;
    logic                 too_long;
  } kvlt_res_t;

  // ASCII character classes; bytes above 0x7E and non-space controls are invalid.
  function automatic kvlt_cls_t kvlt_classify(input logic [7:0] c);
    kvlt_cls_t cls;
    priority if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) cls = CL_SPACE;
    else if (c >= CH_DIG_LO && c <= CH_DIG_HI) cls = CL_DIGIT;
    else if (c >= CH_UP_LO && c <= CH_UP_HI)   cls = CL_UPPER;
    else if (c >= CH_LOW_LO && c <= CH_LOW_HI) cls = CL_LOWER;
    else if (c == CH_EQUAL)                    cls = CL_EQUAL;
    else if (c == CH_HASH)                     cls = CL_HASH;
    else if (c >= CH_PRT_LO && c <= CH_PRT_HI) cls = CL_PUNCT;
    else                                       cls = CL_INVALID;
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ rtl/key_value_line_tokenizer.sv @@
// Key/value line tokenizer, top level: input register, scanner, result register.
// A line-end character goes from the input register through the scanner into the result register.
// Throughput: one character beat per cycle; a waiting result stalls only line ends.
// The scanner holds the rate: one phase update and one 64-bit shift-add per beat.
// Reset (synchronous, rst_n low) empties both registers and starts a fresh line.
// Uses kvlt_pkg and instantiates kvlt_scanner.
`default_nettype none

module key_value_line_tokenizer
  import kvlt_pkg::*;
#(
  parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
  parameter int KEY_LIMIT   = KEY_LIMIT_DEF,
  parameter int VALUE_LIMIT = VALUE_LIMIT_DEF,
  parameter int TABLE_ROWS  = TABLE_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [7:0]           in_ch,
  input  wire logic                 in_line_end,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic                 out_line_ok,
  output      logic [POS_OUT_W-1:0] out_key_start,
  output      logic [POS_OUT_W-1:0] out_key_end,
  output      logic [POS_OUT_W-1:0] out_value_start,
  output      logic [POS_OUT_W-1:0] out_value_end,
  output      logic [63:0]          out_key_hash,
  output      logic [ROW_OUT_W-1:0] out_row,
  output      logic                 out_too_long
);

  logic       in_v_r, in_v_nxt;
  logic [7:0] in_ch_r;
  logic       in_last_r;
  logic       out_v_r, out_v_nxt;
  kvlt_res_t  res_r;
  kvlt_res_t  scan_res;
  logic       in_take;
  logic       advance;
  logic       load;

  // A held character moves on unless it closes a line and the result slot is blocked.
  always_comb begin
    advance  = in_v_r & (~in_last_r | ~out_v_r | ~out_stall);
    load     = advance & in_last_r;
    in_stall = in_v_r & ~advance;
    in_take  = in_valid & ~in_stall;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  kvlt_scanner #(
    .LINE_LIMIT (LINE_LIMIT),
    .KEY_LIMIT  (KEY_LIMIT),
    .VALUE_LIMIT(VALUE_LIMIT),
    .TABLE_ROWS (TABLE_ROWS)
  ) u_scanner (
    .clk   (clk),
    .rst_n (rst_n),
    .step_i(advance),
    .ch_i  (in_ch_r),
    .last_i(in_last_r),
    .res_o (scan_res)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_ch_r   <= in_ch;
      in_last_r <= in_line_end;
    end
    if (load) begin
      res_r <= scan_res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_line_ok     = res_r.line_ok;
  assign out_key_start   = res_r.key_start;
  assign out_key_end     = res_r.key_end;
  assign out_value_start = res_r.value_start;
  assign out_value_end   = res_r.value_end;
  assign out_key_hash    = res_r.key_hash;
  assign out_row         = res_r.row;
  assign out_too_long    = res_r.too_long;

endmodule

`default_nettype wire

@@ rtl/kvlt_row.sv @@
// Table row tracker: keeps the key hash modulo the row count, one character a beat.
// Uses kvlt_pkg; driven by kvlt_scanner.
`default_nettype none

module kvlt_row
  import kvlt_pkg::*;
#(
  parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_i,
  input  wire logic                 last_i,
  input  wire logic                 hash_en_i,
  input  wire logic [7:0]           ch_i,
  input  wire logic [OVF_W-1:0]     ovf_i,
  output      logic [ROW_OUT_W-1:0] row_o
);

  localparam int RES_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int RES_N = 1 << RES_W;
  localparam int SUM_W = RES_W + 2;
  localparam int OVF_N = 1 << OVF_W;
  localparam logic [63:0] ROWS64   = 64'(TABLE_ROWS);
  // 2^64 mod rows, for the part of the product that wraps out of 64 bits.
  localparam logic [63:0] WRAP_M1  = 64'hFFFF_FFFF_FFFF_FFFF % ROWS64;
  localparam logic [63:0] WRAP_RES = (WRAP_M1 + 64'd1) % ROWS64;
  localparam logic [RES_W-1:0] SEED_RES = RES_W'(HASH_SEED % ROWS64);
  localparam logic [SUM_W-1:0] ROWS_S   = SUM_W'(TABLE_ROWS);
  localparam logic [SUM_W-1:0] ROWS2_S  = SUM_W'(2 * TABLE_ROWS);

  logic [RES_W-1:0] mul_tbl [RES_N];
  logic [RES_W-1:0] chr_tbl [256];
  logic [RES_W-1:0] neg_tbl [OVF_N];

  logic [RES_W-1:0] res_r;
  logic [RES_W-1:0] res_nxt;
  logic [RES_W-1:0] res_upd;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] red;

  // Constant tables: residue times 33, character, and minus the wrapped part.
  for (genvar k = 0; k < RES_N; k++) begin : g_mul
    localparam logic [63:0] MV = (64'(k) * 64'd33) % ROWS64;
    assign mul_tbl[k] = RES_W'(MV);
  end

  for (genvar k = 0; k < 256; k++) begin : g_chr
    localparam logic [63:0] CV = 64'(k) % ROWS64;
    assign chr_tbl[k] = RES_W'(CV);
  end

  for (genvar k = 0; k < OVF_N; k++) begin : g_neg
    localparam logic [63:0] NV = (ROWS64 - (64'(k) * WRAP_RES) % ROWS64) % ROWS64;
    assign neg_tbl[k] = RES_W'(NV);
  end

  // Three residues below the row count sum to less than three times it.
  always_comb begin
    sum = SUM_W'(mul_tbl[res_r]) + SUM_W'(chr_tbl[ch_i]) + SUM_W'(neg_tbl[ovf_i]);
    priority if (sum >= ROWS2_S) red = sum - ROWS2_S;
    else if (sum >= ROWS_S)      red = sum - ROWS_S;
    else                         red = sum;
    res_upd = hash_en_i ? RES_W'(red) : res_r;
    if (step_i) begin
      res_nxt = last_i ? SEED_RES : res_upd;
    end else begin
      res_nxt = res_r;
    end
  end

  assign row_o = ROW_OUT_W'(res_upd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= SEED_RES;
    end else begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/kvlt_scanner.sv @@
// Line scanner: phase tracking, key and value bounds, djb2 hash and length checks.
// Uses kvlt_pkg and instantiates kvlt_row.
`default_nettype none

module kvlt_scanner
  import kvlt_pkg::*;
#(
  parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
  parameter int KEY_LIMIT   = KEY_LIMIT_DEF,
  parameter int VALUE_LIMIT = VALUE_LIMIT_DEF,
  parameter int TABLE_ROWS  = TABLE_ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_i,
  input  wire logic [7:0] ch_i,
  input  wire logic       last_i,
  output      kvlt_res_t  res_o
);

  localparam int POS_W = $clog2(LINE_LIMIT);
  localparam int SUM_W = 64 + OVF_W;
  localparam logic [POS_W-1:0] POS_STOP = POS_W'(LINE_LIMIT - 1);
  localparam logic [31:0] KEY_LEN_MAX = 32'(KEY_LIMIT);
  localparam logic [31:0] VAL_LEN_MAX = 32'(VALUE_LIMIT - 1);

  kvlt_phase_t      phase_r, phase_nxt, phase_upd;
  logic             stop_r, stop_nxt, stop_upd;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_upd;
  logic [POS_W-1:0] kf_r, kf_nxt, kf_upd;
  logic [POS_W-1:0] kl_r, kl_nxt, kl_upd;
  logic [POS_W-1:0] vf_r, vf_nxt, vf_upd;
  logic [POS_W-1:0] vl_r, vl_nxt, vl_upd;
  logic             klong_r, klong_nxt, klong_upd;
  logic             vlong_r, vlong_nxt, vlong_upd;
  logic [63:0]      hash_r, hash_nxt, hash_upd;
  logic [SUM_W-1:0] hash_sum;
  logic             hash_en;
  kvlt_cls_t        cls;
  logic             found;
  logic             too_long;
  logic [ROW_OUT_W-1:0] row;

  // Row residue follows the hash step for step.
  kvlt_row #(
    .TABLE_ROWS(TABLE_ROWS)
  ) u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step_i),
    .last_i   (last_i),
    .hash_en_i(hash_en),
    .ch_i     (ch_i),
    .ovf_i    (hash_sum[SUM_W-1:64]),
    .row_o    (row)
  );

  // Per-character scan: updated state before the line-end clear.
  always_comb begin
    cls       = kvlt_classify(ch_i);
    hash_sum  = (SUM_W'(hash_r) << 5) + SUM_W'(hash_r) + SUM_W'(ch_i);
    hash_en   = 1'b0;
    phase_upd = phase_r;
    stop_upd  = stop_r;
    pos_upd   = pos_r;
    kf_upd    = kf_r;
    kl_upd    = kl_r;
    vf_upd    = vf_r;
    vl_upd    = vl_r;
    klong_upd = klong_r;
    vlong_upd = vlong_r;
    if (pos_r < POS_STOP) begin
      pos_upd = pos_r + POS_W'(1);
      if (!stop_r) begin
        if (cls == CL_INVALID || cls == CL_HASH) begin
          stop_upd = 1'b1;
        end else begin
          unique case (phase_r)
            PH_KEY_SEEK: begin
              if (cls == CL_UPPER || cls == CL_LOWER) begin
                kf_upd    = pos_r;
                hash_en   = 1'b1;
                phase_upd = PH_KEY_READ;
              end
            end
            PH_KEY_READ: begin
              if (cls == CL_SPACE || cls == CL_EQUAL) begin
                kl_upd    = pos_r - POS_W'(1);
                klong_upd = 32'(pos_r - kf_r) >= KEY_LEN_MAX;
                phase_upd = (cls == CL_SPACE) ? PH_EQ_WAIT : PH_VAL_SEEK;
              end else begin
                hash_en = 1'b1;
              end
            end
            PH_EQ_WAIT: begin
              if (cls == CL_EQUAL) phase_upd = PH_VAL_SEEK;
            end
            PH_VAL_SEEK: begin
              if (cls != CL_SPACE) begin
                vf_upd    = pos_r;
                vl_upd    = pos_r;
                vlong_upd = 1'b0;
                phase_upd = PH_VAL_READ;
              end
            end
            PH_VAL_READ: begin
              if (cls == CL_SPACE) begin
                stop_upd = 1'b1;
              end else begin
                vl_upd    = pos_r;
                vlong_upd = 32'(pos_r - vf_r) >= VAL_LEN_MAX;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    hash_upd = hash_en ? hash_sum[63:0] : hash_r;
  end

  // Result for a line end; a line with no complete pair reports zeros.
  always_comb begin
    found    = (phase_upd == PH_VAL_READ);
    too_long = klong_upd | vlong_upd;
    res_o    = '0;
    if (found) begin
      res_o.line_ok     = ~too_long;
      res_o.key_start   = POS_OUT_W'(kf_upd);
      res_o.key_end     = POS_OUT_W'(kl_upd);
      res_o.value_start = POS_OUT_W'(vf_upd);
      res_o.value_end   = POS_OUT_W'(vl_upd);
      res_o.key_hash    = hash_upd;
      res_o.row         = row;
      res_o.too_long    = too_long;
    end
  end

  // Commit on each beat; the line end returns everything to the empty line.
  always_comb begin
    phase_nxt = phase_r;
    stop_nxt  = stop_r;
    pos_nxt   = pos_r;
    kf_nxt    = kf_r;
    kl_nxt    = kl_r;
    vf_nxt    = vf_r;
    vl_nxt    = vl_r;
    klong_nxt = klong_r;
    vlong_nxt = vlong_r;
    hash_nxt  = hash_r;
    if (step_i) begin
      if (last_i) begin
        phase_nxt = PH_KEY_SEEK;
        stop_nxt  = 1'b0;
        pos_nxt   = '0;
        kf_nxt    = '0;
        kl_nxt    = '0;
        vf_nxt    = '0;
        vl_nxt    = '0;
        klong_nxt = 1'b0;
        vlong_nxt = 1'b0;
        hash_nxt  = HASH_SEED;
      end else begin
        phase_nxt = phase_upd;
        stop_nxt  = stop_upd;
        pos_nxt   = pos_upd;
        kf_nxt    = kf_upd;
        kl_nxt    = kl_upd;
        vf_nxt    = vf_upd;
        vl_nxt    = vl_upd;
        klong_nxt = klong_upd;
        vlong_nxt = vlong_upd;
        hash_nxt  = hash_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY_SEEK;
      stop_r  <= 1'b0;
      pos_r   <= '0;
      kf_r    <= '0;
      kl_r    <= '0;
      vf_r    <= '0;
      vl_r    <= '0;
      klong_r <= 1'b0;
      vlong_r <= 1'b0;
      hash_r  <= HASH_SEED;
    end else begin
      phase_r <= phase_nxt;
      stop_r  <= stop_nxt;
      pos_r   <= pos_nxt;
      kf_r    <= kf_nxt;
      kl_r    <= kl_nxt;
      vf_r    <= vf_nxt;
      vl_r    <= vl_nxt;
      klong_r <= klong_nxt;
      vlong_r <= vlong_nxt;
      hash_r  <= hash_nxt;
    end
  end

endmodule

`default_nettype wire

@@ verif/key_value_line_tokenizer_tb.sv @@
// Self-checking testbench for key_value_line_tokenizer: character beats in, line results out.
// Predicts each line result in SystemVerilog from the scanned characters and checks every field.
// Depends on kvlt_pkg and rtl/key_value_line_tokenizer.sv.
module key_value_line_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kvlt_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } char_beat_t;

  localparam int TARGET_CHARS = 1150;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_ch = 8'h00;
  logic                 in_line_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_line_ok;
  logic [POS_OUT_W-1:0] out_key_start;
  logic [POS_OUT_W-1:0] out_key_end;
  logic [POS_OUT_W-1:0] out_value_start;
  logic [POS_OUT_W-1:0] out_value_end;
  logic [63:0]          out_key_hash;
  logic [ROW_OUT_W-1:0] out_row;
  logic                 out_too_long;

  // Stimulus, expectations and bookkeeping.
  char_beat_t  char_beats[$];
  logic [7:0]  line_buf[$];
  kvlt_res_t   expected_lines[$];
  int          errors = 0;
  int          chars_taken = 0;
  int          sender_idle_pct = 34;
  int          recv_idle_pct = 49;
  bit          in_took = 1'b0;
  int          hold_left = 0;
  bit          hold_used = 1'b0;

  // Scanner state of the line being predicted.
  kvlt_phase_t scan_phase;
  bit          scan_stopped;
  logic [7:0]  line_pos;
  logic [7:0]  key_lo, key_hi, val_lo, val_hi;
  bit          key_lo_ok, key_hi_ok, val_lo_ok, val_hi_ok;
  logic [63:0] line_hash;

  key_value_line_tokenizer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_ok     (out_line_ok),
    .out_key_start   (out_key_start),
    .out_key_end     (out_key_end),
    .out_value_start (out_value_start),
    .out_value_end   (out_value_end),
    .out_key_hash    (out_key_hash),
    .out_row         (out_row),
    .out_too_long    (out_too_long)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ASCII classes: white space includes tab through carriage return.
  function automatic kvlt_cls_t char_kind(logic [7:0] c);
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return CL_SPACE;
    if (c >= CH_DIG_LO && c <= CH_DIG_HI) return CL_DIGIT;
    if (c >= CH_UP_LO && c <= CH_UP_HI) return CL_UPPER;
    if (c >= CH_LOW_LO && c <= CH_LOW_HI) return CL_LOWER;
    if (c == CH_EQUAL) return CL_EQUAL;
    if (c == CH_HASH) return CL_HASH;
    if (c >= CH_PRT_LO && c <= CH_PRT_HI) return CL_PUNCT;
    return CL_INVALID;
  endfunction

  function void restart_line();
    scan_phase   = PH_KEY_SEEK;
    scan_stopped = 1'b0;
    line_pos     = 8'd0;
    key_lo = 8'd0; key_hi = 8'd0; val_lo = 8'd0; val_hi = 8'd0;
    key_lo_ok = 1'b0; key_hi_ok = 1'b0; val_lo_ok = 1'b0; val_hi_ok = 1'b0;
    line_hash = HASH_SEED;
  endfunction

  // Advance the scanner by one accepted character; a line end queues the line's result.
  function void tokenize_char(logic [7:0] c, logic last);
    kvlt_cls_t k;
    kvlt_res_t res;
    int        klen, vlen;
    bit        over;
    k = char_kind(c);
    if (line_pos < 8'(LINE_LIMIT_DEF - 1)) begin
      if (!scan_stopped) begin
        if (k == CL_INVALID || k == CL_HASH) begin
          scan_stopped = 1'b1;
        end else begin
          case (scan_phase)
            PH_KEY_SEEK: begin
              if (k == CL_UPPER || k == CL_LOWER) begin
                key_lo = line_pos; key_lo_ok = 1'b1;
                line_hash = line_hash * 64'd33 + {56'd0, c};
                scan_phase = PH_KEY_READ;
              end
            end
            PH_KEY_READ: begin
              if (k == CL_SPACE || k == CL_EQUAL) begin
                key_hi = line_pos - 8'd1; key_hi_ok = 1'b1;
                scan_phase = (k == CL_SPACE) ? PH_EQ_WAIT : PH_VAL_SEEK;
              end else begin
                line_hash = line_hash * 64'd33 + {56'd0, c};
              end
            end
            PH_EQ_WAIT: begin
              if (k == CL_EQUAL) scan_phase = PH_VAL_SEEK;
            end
            PH_VAL_SEEK: begin
              if (k != CL_SPACE) begin
                val_lo = line_pos; val_lo_ok = 1'b1;
                val_hi = line_pos; val_hi_ok = 1'b1;
                scan_phase = PH_VAL_READ;
              end
            end
            default: begin
              // A space closes the value and ends the scan for this line.
              if (k == CL_SPACE) scan_stopped = 1'b1;
              else val_hi = line_pos;
            end
          endcase
        end
      end
      line_pos = line_pos + 8'd1;
    end
    if (last) begin
      res = '0;
      if (key_lo_ok && key_hi_ok && val_lo_ok && val_hi_ok) begin
        klen = key_hi - key_lo + 1;
        vlen = val_hi - val_lo + 1;
        over = (klen > KEY_LIMIT_DEF - 1) || (vlen > VALUE_LIMIT_DEF - 1);
        res.line_ok     = !over;
        res.key_start   = key_lo;
        res.key_end     = key_hi;
        res.value_start = val_lo;
        res.value_end   = val_hi;
        res.key_hash    = line_hash;
        res.row         = ROW_OUT_W'(line_hash % TABLE_ROWS_DEF);
        res.too_long    = over;
      end
      expected_lines.push_back(res);
      restart_line();
    end
  endfunction

  task flag_error(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Stimulus helpers: a line is built in line_buf, then closed into beats.
  function void close_line();
    char_beat_t b;
    foreach (line_buf[i]) begin
      b.ch       = line_buf[i];
      b.line_end = (i == line_buf.size() - 1);
      char_beats.push_back(b);
    end
    line_buf.delete();
  endfunction

  function void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    close_line();
  endfunction

  function automatic logic [7:0] rand_char(kvlt_cls_t k);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (char_kind(c) != k);
    return c;
  endfunction

  function automatic logic [7:0] rand_body_char(bit allow_eq);
    case ($urandom_range(0, 4))
      0: return rand_char(CL_UPPER);
      1: return rand_char(CL_LOWER);
      2: return rand_char(CL_DIGIT);
      3: return rand_char(CL_PUNCT);
      default: return allow_eq ? CH_EQUAL : rand_char(CL_LOWER);
    endcase
  endfunction

  // A key/value line with random spacing and tail; corrupt drops in a stop character.
  function automatic void add_pair_line(int klen, int vlen, bit corrupt);
    int n, idx;
    n = $urandom_range(0, 2);
    repeat (n) line_buf.push_back($urandom_range(0, 1) ? rand_char(CL_SPACE) :
                                  rand_char(CL_DIGIT));
    line_buf.push_back(rand_char($urandom_range(0, 1) ? CL_UPPER : CL_LOWER));
    repeat (klen - 1) line_buf.push_back(rand_body_char(1'b0));
    case ($urandom_range(0, 3))
      0: line_buf.push_back(CH_EQUAL);
      1: begin
        line_buf.push_back(rand_char(CL_SPACE));
        line_buf.push_back(CH_EQUAL);
      end
      2: begin
        // Junk between the key and '=' is skipped by the scanner.
        line_buf.push_back(rand_char(CL_SPACE));
        if ($urandom_range(0, 1)) line_buf.push_back(rand_body_char(1'b0));
        line_buf.push_back(CH_EQUAL);
        line_buf.push_back(rand_char(CL_SPACE));
      end
      default: begin
        line_buf.push_back(CH_EQUAL);
        repeat ($urandom_range(1, 3)) line_buf.push_back(rand_char(CL_SPACE));
      end
    endcase
    repeat (vlen) line_buf.push_back(rand_body_char(1'b1));
    case ($urandom_range(0, 2))
      0: ;
      1: begin
        line_buf.push_back(rand_char(CL_SPACE));
        repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        line_buf.push_back(rand_char(CL_SPACE));
        line_buf.push_back(CH_HASH);
        repeat ($urandom_range(0, 4)) line_buf.push_back(rand_body_char(1'b1));
      end
    endcase
    if (corrupt) begin
      idx = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: line_buf[idx] = CH_HASH;
        1: line_buf[idx] = 8'($urandom_range(8'h80, 8'hFF));
        default: line_buf[idx] = 8'($urandom_range(8'h00, 8'h08));
      endcase
    end
    close_line();
  endfunction

  // Lines that lack a key end, an '=' or a value.
  function automatic void add_broken_line();
    int j;
    j = $urandom_range(0, 3);
    line_buf.push_back(rand_char(CL_LOWER));
    repeat ($urandom_range(0, 5)) line_buf.push_back(rand_body_char(1'b0));
    case (j)
      0: if ($urandom_range(0, 1)) line_buf.push_back(rand_char(CL_SPACE));
      1: begin
        line_buf.push_back(CH_EQUAL);
        repeat ($urandom_range(0, 3)) line_buf.push_back(rand_char(CL_SPACE));
      end
      2: begin
        line_buf.push_front(CH_HASH);
        line_buf.push_back(CH_EQUAL);
        line_buf.push_back(rand_body_char(1'b1));
      end
      default: begin
        line_buf.push_back(rand_char(CL_SPACE));
        repeat ($urandom_range(1, 5)) line_buf.push_back(rand_body_char(1'b0));
      end
    endcase
    close_line();
  endfunction

  // Sender: a new beat is offered once the previous one is taken or none was offered.
  always @(negedge clk) begin
    char_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (char_beats.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = char_beats.pop_front();
        in_valid    <= 1'b1;
        in_ch       <= nxt.ch;
        in_line_end <= nxt.line_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_used && chars_taken >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: check result beats, then feed accepted character beats to the predictor.
  always @(posedge clk) begin
    kvlt_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          flag_error("result beat with no line pending");
        end else begin
          want = expected_lines.pop_front();
          check_field("line_ok", 64'(out_line_ok), 64'(want.line_ok));
          check_field("key_start", 64'(out_key_start), 64'(want.key_start));
          check_field("key_end", 64'(out_key_end), 64'(want.key_end));
          check_field("value_start", 64'(out_value_start), 64'(want.value_start));
          check_field("value_end", 64'(out_value_end), 64'(want.value_end));
          check_field("key_hash", out_key_hash, want.key_hash);
          check_field("row", 64'(out_row), 64'(want.row));
          check_field("too_long", 64'(out_too_long), 64'(want.too_long));
        end
      end
      in_took = in_valid && !in_stall;
      if (in_took) begin
        tokenize_char(in_ch, in_line_end);
        chars_taken++;
      end
    end else begin
      in_took = 1'b0;
    end
  end

  // Main sequence: build stimulus, release reset, step the idling pattern, drain.
  initial begin
    int total, line_no, pick, n;
    restart_line();

    // Directed lines: basic pair, spaced key, unclosed key, comment before value,
    // invalid bytes at both ends of the range, '=' before any key, value closed by space, a blank line.
    push_text("a=1");
    push_text(" Zy =x");
    push_text("ab");
    push_text("k=#");
    line_buf.push_back(8'hFF);
    close_line();
    line_buf.push_back(8'h00);
    close_line();
    push_text("=q");
    push_text("b=~ ");
    push_text(" ");

    // Random lines, with keys and values at their limits and one overlong line.
    line_no = 0;
    while (char_beats.size() < TARGET_CHARS) begin
      line_no++;
      case (line_no)
        3:  add_pair_line(KEY_LIMIT_DEF - 1, 2, 1'b0);
        6:  add_pair_line(KEY_LIMIT_DEF, 2, 1'b0);
        9:  add_pair_line(3, VALUE_LIMIT_DEF - 1, 1'b0);
        12: add_pair_line(3, VALUE_LIMIT_DEF, 1'b0);
        15: add_pair_line(2, LINE_LIMIT_DEF + 20, 1'b0);
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 60) begin
            add_pair_line($urandom_range(1, 8), $urandom_range(1, 10), 1'b0);
          end else if (pick < 70) begin
            add_broken_line();
          end else if (pick < 80) begin
            add_pair_line($urandom_range(1, 8), $urandom_range(1, 10), 1'b1);
          end else begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
            close_line();
          end
        end
      endcase
    end
    total = char_beats.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (chars_taken < total / 3) @(posedge clk);
    sender_idle_pct = 49;
    recv_idle_pct   = 34;
    while (chars_taken < (2 * total) / 3) @(posedge clk);
    sender_idle_pct = 0;
    recv_idle_pct   = 0;

    while (char_beats.size() != 0 || in_valid) @(posedge clk);
    for (n = 0; n < DRAIN_LIMIT && expected_lines.size() != 0; n++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_lines.size() != 0)
      flag_error($sformatf("%0d line results never arrived", expected_lines.size()));

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest passing run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ key_value_line_tokenizer.f @@
rtl/kvlt_pkg.sv
rtl/kvlt_row.sv
rtl/kvlt_scanner.sv
rtl/key_value_line_tokenizer.sv
verif/key_value_line_tokenizer_tb.sv
